/* rtl/aclint_pkg.sv */
// shared types and constants for the aclint timer and software interrupt block
// no dependencies
`timescale 1ns / 1ps

package aclint_pkg;

	localparam int HARTS_DEF = 4;
	localparam int OFFSET_W  = 15;
	localparam int DATA_W    = 64;
	localparam int LVL_W     = 4;
	localparam int TIDX_W    = 12;   // timer register index, offset >> 3
	localparam int SIDX_W    = 13;   // msip register index, offset >> 2

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [TIDX_W-1:0] MTIME_IDX = 12'hfff;   // byte offset 0x7ff8

	// decoded access of one word
	typedef struct packed {
		logic tick;
		logic rd;
		logic wr;
		logic sel_mtime;
		logic sel_cmp;
		logic sel_msip;
	} acc_t;

endpackage

/* rtl/aclint_timer_and_soft_interrupt.sv */
// aclint machine timer and machine software interrupt block, top level
// a word passes the input register, the state and read data registers, then the result register
// throughput: one word per cycle, busy never rises; the receiver cannot stall
// reset: async active low; mtime zero, every mtimecmp all ones, msip bits cleared
// depends on aclint_pkg, aclint_dec, aclint_regs, aclint_irq
`timescale 1ns / 1ps

module aclint_timer_and_soft_interrupt import aclint_pkg::*; #(
	parameter int HARTS = HARTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          op,
	input  logic                region,
	input  logic [OFFSET_W-1:0] offset,
	input  logic [DATA_W-1:0]   wdata,
	output logic                done,
	output logic [DATA_W-1:0]   rdata,
	output logic [LVL_W-1:0]    mtip,
	output logic [LVL_W-1:0]    msip
);

	// hart index width, at least one bit so a single hart still elaborates
	localparam int HIDX_W = (HARTS > 1) ? $clog2(HARTS) : 1;

	logic                valid_s1;
	logic [1:0]          op_s1;
	logic                region_s1;
	logic [OFFSET_W-1:0] offset_s1;
	logic [DATA_W-1:0]   wdata_s1;

	acc_t                acc;
	logic [HIDX_W-1:0]   hart;

	logic [DATA_W-1:0]   mtime_q;
	logic [DATA_W-1:0]   mtimecmp_q [HARTS];
	logic [HARTS-1:0]    msip_q;
	logic [DATA_W-1:0]   rdata_s2;
	logic                done_s2;

	// every cycle is free to take a word: the whole access fits one stage
	assign busy = 1'b0;

	// input register: control is reset, payload is not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1     <= op;
			region_s1 <= region;
			offset_s1 <= offset;
			wdata_s1  <= wdata;
		end
	end

	// decode the registered word into register selects and a hart index
	aclint_dec #(
		.HARTS  (HARTS),
		.HIDX_W (HIDX_W)
	) u_dec (
		.op     (op_s1),
		.region (region_s1),
		.offset (offset_s1),
		.acc    (acc),
		.hart   (hart)
	);

	// state update and read data; the state registers then hold the levels
	// that follow this word, so the compare in the next stage sees them
	aclint_regs #(
		.HARTS  (HARTS),
		.HIDX_W (HIDX_W)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.acc        (acc),
		.hart       (hart),
		.wdata_s1   (wdata_s1),
		.mtime_q    (mtime_q),
		.mtimecmp_q (mtimecmp_q),
		.msip_q     (msip_q),
		.rdata_s2   (rdata_s2),
		.done_s2    (done_s2)
	);

	// parallel per-hart compare and the result register; a following word
	// updates the state at the same edge this one samples it, so the levels
	// are exactly those after this word
	aclint_irq #(
		.HARTS (HARTS)
	) u_irq (
		.clk        (clk),
		.arst_n     (arst_n),
		.done_s2    (done_s2),
		.rdata_s2   (rdata_s2),
		.mtime_q    (mtime_q),
		.mtimecmp_q (mtimecmp_q),
		.msip_q     (msip_q),
		.done_q     (done),
		.rdata_q    (rdata),
		.mtip_q     (mtip),
		.msip_lvl_q (msip)
	);

endmodule

/* rtl/aclint_dec.sv */
// address and operation decode of one word
// depends on aclint_pkg
`timescale 1ns / 1ps

module aclint_dec import aclint_pkg::*; #(
	parameter int HARTS  = HARTS_DEF,
	parameter int HIDX_W = 2
) (
	input  logic [1:0]          op,
	input  logic                region,
	input  logic [OFFSET_W-1:0] offset,
	output acc_t                acc,
	output logic [HIDX_W-1:0]   hart
);

	logic [TIDX_W-1:0] tidx;
	logic [SIDX_W-1:0] sidx;

	assign tidx = offset[OFFSET_W-1:3];
	assign sidx = offset[OFFSET_W-1:2];

	always_comb begin
		acc = '0;
		unique case (op)
			OP_TICK:  acc.tick = 1'b1;
			OP_READ:  acc.rd   = 1'b1;
			OP_WRITE: acc.wr   = 1'b1;
			default:  acc      = '0;
		endcase
		acc.sel_mtime = !region && (tidx == MTIME_IDX);
		acc.sel_cmp   = !region && (tidx < TIDX_W'(HARTS));
		acc.sel_msip  = region && (sidx < SIDX_W'(HARTS));
	end

	assign hart = region ? sidx[HIDX_W-1:0] : tidx[HIDX_W-1:0];

endmodule

/* rtl/aclint_regs.sv */
// mtime, mtimecmp and msip state with the read data register
// depends on aclint_pkg
`timescale 1ns / 1ps

module aclint_regs import aclint_pkg::*; #(
	parameter int HARTS  = HARTS_DEF,
	parameter int HIDX_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  acc_t              acc,
	input  logic [HIDX_W-1:0] hart,
	input  logic [DATA_W-1:0] wdata_s1,
	output logic [DATA_W-1:0] mtime_q,
	output logic [DATA_W-1:0] mtimecmp_q [HARTS],
	output logic [HARTS-1:0]  msip_q,
	output logic [DATA_W-1:0] rdata_s2,
	output logic              done_s2
);

	logic [DATA_W-1:0] rd_val;

	// read mux, out-of-range offsets read zero
	always_comb begin
		rd_val = '0;
		if (acc.rd) begin
			if (acc.sel_mtime) begin
				rd_val = mtime_q;
			end else if (acc.sel_cmp) begin
				rd_val = mtimecmp_q[hart];
			end else if (acc.sel_msip) begin
				rd_val = DATA_W'(msip_q[hart]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtime_q <= '0;
			msip_q  <= '0;
			done_s2 <= 1'b0;
			for (int h = 0; h < HARTS; h++) begin
				mtimecmp_q[h] <= '1;
			end
		end else begin
			done_s2 <= valid_s1;
			if (valid_s1) begin
				if (acc.tick) begin
					mtime_q <= mtime_q + DATA_W'(1);
				end
				if (acc.wr) begin
					if (acc.sel_mtime) begin
						mtime_q <= wdata_s1;
					end else if (acc.sel_cmp) begin
						mtimecmp_q[hart] <= wdata_s1;
					end else if (acc.sel_msip) begin
						msip_q[hart] <= wdata_s1[0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_s2 <= rd_val;
	end

endmodule

/* rtl/aclint_irq.sv */
// per-hart timer compare and the result register
// depends on aclint_pkg
`timescale 1ns / 1ps

module aclint_irq import aclint_pkg::*; #(
	parameter int HARTS = HARTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              done_s2,
	input  logic [DATA_W-1:0] rdata_s2,
	input  logic [DATA_W-1:0] mtime_q,
	input  logic [DATA_W-1:0] mtimecmp_q [HARTS],
	input  logic [HARTS-1:0]  msip_q,
	output logic              done_q,
	output logic [DATA_W-1:0] rdata_q,
	output logic [LVL_W-1:0]  mtip_q,
	output logic [LVL_W-1:0]  msip_lvl_q
);

	logic [LVL_W-1:0] mtip_d;
	logic [LVL_W-1:0] msip_d;

	// harts above the visible field width keep state but are not reported
	always_comb begin
		mtip_d = '0;
		msip_d = '0;
		for (int h = 0; h < LVL_W; h++) begin
			if (h < HARTS) begin
				mtip_d[h] = (mtimecmp_q[h] <= mtime_q);
				msip_d[h] = msip_q[h];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= done_s2;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q    <= rdata_s2;
		mtip_q     <= mtip_d;
		msip_lvl_q <= msip_d;
	end

endmodule

/* tb/tb_aclint_timer_and_soft_interrupt.sv */
// self-checking testbench for the aclint machine timer and software interrupt block
// predicts every result word in a small scoreboard class; needs only aclint_pkg and the rtl
`timescale 1ns / 1ps

module tb_aclint_timer_and_soft_interrupt;
	import aclint_pkg::*;

	localparam int NH = HARTS_DEF;
	localparam int N_RANDOM = 800;
	localparam int QUIET_TAIL = 100;       // last words go out back to back
	localparam int STALL_LIMIT = 2000;     // cycles with no word moving on either side
	localparam logic [1:0] OP_NONE = 2'd3;  // unused op code, does nothing
	localparam logic [OFFSET_W-1:0] MTIME_OFF = 15'h7ff8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] op;
	logic region;
	logic [OFFSET_W-1:0] offset;
	logic [DATA_W-1:0] wdata;
	logic done;
	logic [DATA_W-1:0] rdata;
	logic [LVL_W-1:0] mtip;
	logic [LVL_W-1:0] msip;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic [LVL_W-1:0]  mtip;
		logic [LVL_W-1:0]  msip;
	} result_word_t;

	// timer and msip state as the block should hold it, plus the words still owed
	class aclint_scoreboard;
		logic [DATA_W-1:0] mtime;
		logic [DATA_W-1:0] cmp [NH];
		logic              sw_pend [NH];
		result_word_t      owed_q [$];
		int                fails;
		int                op_count [4];
		int                timer_irq_words;
		int                soft_irq_words;

		function new();
			mtime = '0;
			for (int h = 0; h < NH; h++) begin
				cmp[h]     = '1;
				sw_pend[h] = 1'b0;
			end
			fails = 0;
			timer_irq_words = 0;
			soft_irq_words = 0;
			for (int i = 0; i < 4; i++)
				op_count[i] = 0;
		endfunction

		// apply one accepted word to the state and queue the result it must give
		function void note(logic [1:0] o, logic reg_sel, logic [OFFSET_W-1:0] off,
				logic [DATA_W-1:0] d);
			result_word_t r;
			logic [TIDX_W-1:0] tidx;
			logic [SIDX_W-1:0] sidx;
			r = '0;
			tidx = off[OFFSET_W-1:3];
			sidx = off[OFFSET_W-1:2];
			op_count[o]++;
			case (o)
				OP_TICK: begin
					mtime = mtime + 64'd1;
				end
				OP_READ: begin
					if (reg_sel) begin
						if (sidx < NH)
							r.rdata = {63'd0, sw_pend[sidx]};
					end else if (tidx == MTIME_IDX) begin
						r.rdata = mtime;
					end else if (tidx < NH) begin
						r.rdata = cmp[tidx];
					end
				end
				OP_WRITE: begin
					if (reg_sel) begin
						if (sidx < NH)
							sw_pend[sidx] = d[0];
					end else if (tidx == MTIME_IDX) begin
						mtime = d;
					end else if (tidx < NH) begin
						cmp[tidx] = d;
					end
				end
				default: ;
			endcase
			for (int h = 0; h < NH && h < LVL_W; h++) begin
				r.mtip[h] = (cmp[h] <= mtime);
				r.msip[h] = sw_pend[h];
			end
			if (r.mtip != '0)
				timer_irq_words++;
			if (r.msip != '0)
				soft_irq_words++;
			owed_q.push_back(r);
		endfunction

		function void check(logic [DATA_W-1:0] rd, logic [LVL_W-1:0] ti,
				logic [LVL_W-1:0] si);
			result_word_t e;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result word rdata %h mtip %b msip %b",
					$time, rd, ti, si);
				fails++;
				return;
			end
			e = owed_q.pop_front();
			if (rd !== e.rdata) begin
				$display("%0t: rdata expected %h actual %h", $time, e.rdata, rd);
				fails++;
			end
			if (ti !== e.mtip) begin
				$display("%0t: mtip expected %b actual %b", $time, e.mtip, ti);
				fails++;
			end
			if (si !== e.msip) begin
				$display("%0t: msip expected %b actual %b", $time, e.msip, si);
				fails++;
			end
		endfunction

		function int owed();
			return owed_q.size();
		endfunction
	endclass

	aclint_scoreboard sb;
	int stall_cycles;

	aclint_timer_and_soft_interrupt #(.HARTS(NH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.region (region),
		.offset (offset),
		.wdata  (wdata),
		.done   (done),
		.rdata  (rdata),
		.mtip   (mtip),
		.msip   (msip)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// sample both sides at the rising edge: inputs only move on the falling edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(op, region, offset, wdata);
			if (done)
				sb.check(rdata, mtip, msip);
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			// nothing moved for far longer than any gap or latency
			if (stall_cycles == STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// present one word and hold it until the block takes it; start stays high
	// so back to back words go out with no gap
	task automatic send_word(logic [1:0] o, logic reg_sel, logic [OFFSET_W-1:0] off,
			logic [DATA_W-1:0] d);
		@(negedge clk);
		start  = 1'b1;
		op     = o;
		region = reg_sel;
		offset = off;
		wdata  = d;
		do
			@(posedge clk);
		while (busy);
	endtask

	// sender idles; the fields carry junk that must be ignored
	task automatic idle_gap(int n);
		@(negedge clk);
		start  = 1'b0;
		op     = 2'($urandom);
		region = 1'($urandom);
		offset = OFFSET_W'($urandom);
		wdata  = {$urandom, $urandom};
		repeat (n) @(posedge clk);
	endtask

	// hold off until every owed result word has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.owed() != 0)
			@(posedge clk);
	endtask

	// random word biased toward values that make the compares flip:
	// mtimecmp written near mtime, mtime written near a compare value or the wrap
	function automatic void pick_word(output logic [1:0] o, output logic reg_sel,
			output logic [OFFSET_W-1:0] off, output logic [DATA_W-1:0] d);
		int k;
		int h;
		k = $urandom_range(0, 19);
		h = $urandom_range(0, NH - 1);
		if (k < 7)
			o = OP_TICK;
		else if (k < 13)
			o = OP_READ;
		else if (k < 19)
			o = OP_WRITE;
		else
			o = OP_NONE;
		reg_sel = 1'($urandom);

		k = $urandom_range(0, 9);
		if (reg_sel) begin
			if (k < 7)
				off = OFFSET_W'((h << 2) | $urandom_range(0, 3));
			else
				off = OFFSET_W'($urandom);
		end else begin
			if (k < 6)
				off = OFFSET_W'((h << 3) | $urandom_range(0, 7));
			else if (k < 8)
				off = MTIME_OFF | OFFSET_W'($urandom_range(0, 7));
			else
				off = OFFSET_W'($urandom);
		end

		k = $urandom_range(0, 9);
		case (k)
			0, 1: d = {$urandom, $urandom};
			2, 3, 4, 5: d = sb.mtime + 64'($urandom_range(0, 40)) - 64'd8;
			6: d = ~64'd0 - 64'($urandom_range(0, 20));
			7: d = 64'($urandom_range(0, 20));
			default: d = sb.cmp[$urandom_range(0, NH - 1)] + 64'($urandom_range(0, 6))
				- 64'd3;
		endcase
	endfunction

	initial begin
		logic [1:0] o;
		logic reg_sel;
		logic [OFFSET_W-1:0] off;
		logic [DATA_W-1:0] d;
		bit gaps_on;

		sb = new();
		stall_cycles = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		op     = OP_TICK;
		region = 1'b0;
		offset = '0;
		wdata  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset values, each op, unaligned and out of range offsets, wrap
		send_word(OP_READ,  1'b0, 15'h0000, '0);                      // mtimecmp0 all ones
		send_word(OP_READ,  1'b0, 15'h0018, '0);                      // mtimecmp3
		send_word(OP_READ,  1'b0, MTIME_OFF, '0);
		send_word(OP_READ,  1'b1, 15'h0000, '0);
		send_word(OP_TICK,  1'b0, 15'h0000, '0);
		send_word(OP_WRITE, 1'b0, 15'h0000, 64'd0);                   // hart 0 fires at once
		send_word(OP_WRITE, 1'b0, 15'h0008, 64'd2);
		send_word(OP_TICK,  1'b1, 15'h7fff, '1);                      // hart 1 reaches compare
		send_word(OP_READ,  1'b0, 15'h000f, '0);                      // unaligned, mtimecmp1
		send_word(OP_WRITE, 1'b0, MTIME_OFF, '1);                     // mtime all ones
		send_word(OP_READ,  1'b0, 15'h7fff, '0);                      // unaligned mtime
		send_word(OP_TICK,  1'b0, 15'h0000, '0);                      // mtime wraps to zero
		send_word(OP_WRITE, 1'b1, 15'h0000, 64'hffff_ffff_ffff_fffe); // msip keeps bit 0 only
		send_word(OP_WRITE, 1'b1, 15'h0005, 64'd1);                   // unaligned msip1
		send_word(OP_WRITE, 1'b1, 15'h000c, '1);
		send_word(OP_READ,  1'b1, 15'h0007, '0);
		send_word(OP_WRITE, 1'b1, 15'h0010, 64'd1);                   // no such hart, ignored
		send_word(OP_READ,  1'b1, 15'h7fff, '0);
		send_word(OP_WRITE, 1'b0, 15'h0020, '0);                      // no such hart, ignored
		send_word(OP_READ,  1'b0, 15'h0020, '0);
		send_word(OP_READ,  1'b0, 15'h7ff0, '0);                      // just below mtime
		send_word(OP_NONE,  1'b1, 15'h0000, '1);
		send_word(OP_WRITE, 1'b0, 15'h0018, 64'h8000_0000_0000_0000);
		send_word(OP_WRITE, 1'b0, MTIME_OFF, 64'h7fff_ffff_ffff_ffff);
		send_word(OP_TICK,  1'b0, 15'h0000, '0);                      // top bit decides compare
		drain();

		// random words, sender gaps switched on and off in stretches of 40
		gaps_on = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0)
				gaps_on = ($urandom_range(0, 2) != 0) && (i < N_RANDOM - QUIET_TAIL);
			if (gaps_on && $urandom_range(0, 4) == 0)
				idle_gap($urandom_range(1, 16));
			if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 99) == 0)
				drain();
			pick_word(o, reg_sel, off, d);
			send_word(o, reg_sel, off, d);
		end

		drain();
		repeat (10) @(posedge clk);

		$display("words: %0d ticks, %0d reads, %0d writes, %0d unused op",
			sb.op_count[OP_TICK], sb.op_count[OP_READ], sb.op_count[OP_WRITE],
			sb.op_count[OP_NONE]);
		$display("results with timer interrupt pending: %0d, with software pending: %0d",
			sb.timer_irq_words, sb.soft_irq_words);
		if (sb.fails == 0 && sb.owed() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/aclint_pkg.sv
rtl/aclint_dec.sv
rtl/aclint_regs.sv
rtl/aclint_irq.sv
rtl/aclint_timer_and_soft_interrupt.sv
tb/tb_aclint_timer_and_soft_interrupt.sv
